[hw/rtl/teq_pkg.sv]
package teq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int MAX_FIRED       = 16;
    localparam logic [31:0] MAX_DELTA = 32'h7000_0000;

    typedef enum logic [2:0] {
        OP_INS64  = 3'd0,
        OP_INS32  = 3'd1,
        OP_REMOVE = 3'd2,
        OP_DISP   = 3'd3,
        OP_TIME   = 3'd4,
        OP_PEEK   = 3'd5,
        OP_RSV6   = 3'd6,
        OP_RSV7   = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        K_FIRED    = 3'd0,
        K_COMPARE  = 3'd1,
        K_FIRE_NOW = 3'd2,
        K_TIME     = 3'd3,
        K_NEXT     = 3'd4,
        K_NONE     = 3'd5,
        K_FULL     = 3'd6,
        K_ACK      = 3'd7
    } kind_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_SHIFT_UP,
        S_SHIFT_DN,
        S_HEAD_RD,
        S_HEAD_CHK,
        S_SCHED,
        S_EMIT
    } state_t;

    // one slot of the event store
    typedef struct packed {
        logic [63:0] etime;
        logic [31:0] id;
    } slot_t;

endpackage

[hw/rtl/teq_slot_ram.sv]
module teq_slot_ram
    import teq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int AW = $clog2(QUEUE_DEPTH)
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  slot_t         wr_data,
    input  logic [AW-1:0] rd_addr,
    output slot_t         rd_data
);

    slot_t mem [QUEUE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[hw/rtl/timer_event_queue.sv]
// Insert and remove scan the slots from the head; insert then shifts the later entries
// up to make room and remove shifts them down. Dispatch fires up to MAX_FIRED due events
// from the head, shifting the rest down after each, then reports the next schedule.
// One item is handled at a time; results leave through an output register.
// Reset (rst_n, asynchronous) empties the queue and restarts the time base;
// slot contents are not cleared.
module timer_event_queue
    import teq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  opcode,
    input  logic [31:0] counter_now,
    input  logic [63:0] event_time,
    input  logic [31:0] event_id,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  result_kind,
    output logic [31:0] fired_id,
    output logic [63:0] result_value,
    output logic        last_result
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int FW = $clog2(MAX_FIRED + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [63:0]   present_reg, present_next;
    logic [31:0]   lastcnt_reg, lastcnt_next;
    logic          started_reg, started_next;
    op_t           op_reg, op_next;
    logic [63:0]   tm_reg, tm_next;
    logic [31:0]   id_reg, id_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [FW-1:0] fired_reg, fired_next;
    logic          ovalid_reg, ovalid_next;
    kind_t         kind_reg, kind_next;
    logic [31:0]   fid_reg, fid_next;
    logic [63:0]   val_reg, val_next;
    logic          last_reg, last_next;
    kind_t         pend_kind_reg, pend_kind_next;
    logic          pend_sched_reg, pend_sched_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    slot_t         wr_data, rd_data;

    teq_slot_ram #(.QUEUE_DEPTH(QUEUE_DEPTH), .AW(AW)) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    logic        accept;
    logic [63:0] delta;
    logic [63:0] t32;
    logic [31:0] elapsed;
    logic        out_free;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign out_free = !ovalid_reg || !out_stall;
    assign delta    = rd_data.etime - present_reg;
    assign elapsed  = counter_now - lastcnt_reg;
    assign t32 = {present_reg[63:32], tm_reg[31:0]}
               + ((tm_reg[31:0] < present_reg[31:0]) ? 64'h1_0000_0000 : 64'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            present_reg    <= '0;
            lastcnt_reg    <= '0;
            started_reg    <= 1'b0;
            ovalid_reg     <= 1'b0;
            pend_sched_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            present_reg    <= present_next;
            lastcnt_reg    <= lastcnt_next;
            started_reg    <= started_next;
            ovalid_reg     <= ovalid_next;
            pend_sched_reg <= pend_sched_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        tm_reg        <= tm_next;
        id_reg        <= id_next;
        pos_reg       <= pos_next;
        idx_reg       <= idx_next;
        fired_reg     <= fired_next;
        kind_reg      <= kind_next;
        fid_reg       <= fid_next;
        val_reg       <= val_next;
        last_reg      <= last_next;
        pend_kind_reg <= pend_kind_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        present_next    = present_reg;
        lastcnt_next    = lastcnt_reg;
        started_next    = started_reg;
        op_next         = op_reg;
        tm_next         = tm_reg;
        id_next         = id_reg;
        pos_next        = pos_reg;
        idx_next        = idx_reg;
        fired_next      = fired_reg;
        kind_next       = kind_reg;
        fid_next        = fid_reg;
        val_next        = val_reg;
        last_next       = last_reg;
        pend_kind_next  = pend_kind_reg;
        pend_sched_next = pend_sched_reg;
        ovalid_next     = ovalid_reg && out_stall;
        wr_en           = 1'b0;
        wr_addr         = idx_reg[AW-1:0];
        wr_data         = '{etime: tm_reg, id: id_reg};
        rd_addr         = idx_reg[AW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    started_next = 1'b1;
                    lastcnt_next = counter_now;
                    if (started_reg)
                    begin
                        present_next = present_reg + {32'd0, elapsed};
                    end
                    op_next    = op_t'(opcode);
                    tm_next    = event_time;
                    id_next    = event_id;
                    idx_next   = '0;
                    fired_next = '0;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                // memory read of slot 0 is under way
                idx_next = '0;
                case (op_reg)
                    OP_INS64, OP_INS32:
                    begin
                        if (op_reg == OP_INS32)
                        begin
                            tm_next = t32;
                        end
                        if (count_reg >= FULL_CNT)
                        begin
                            pend_kind_next = K_FULL;
                            state_next     = S_EMIT;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    OP_REMOVE, OP_DISP, OP_PEEK:
                    begin
                        state_next = S_SCAN;
                    end
                    OP_TIME:
                    begin
                        pend_kind_next = K_TIME;
                        state_next     = S_EMIT;
                    end
                    default:
                    begin
                        pend_kind_next = K_NONE;
                        state_next     = S_EMIT;
                    end
                endcase
                pend_sched_next = 1'b0;
            end
            S_SCAN:
            begin
                // rd_data holds slot idx_reg (read issued last cycle)
                case (op_reg)
                    OP_INS64, OP_INS32:
                    begin
                        if (idx_reg < count_reg && tm_reg >= rd_data.etime)
                        begin
                            idx_next = idx_reg + 1'b1;
                            rd_addr  = AW'(idx_reg + 1'b1);
                            state_next = S_HEAD_RD;
                        end
                        else
                        begin
                            pos_next = idx_reg;
                            // shift from the tail down to pos
                            idx_next   = count_reg;
                            state_next = S_SHIFT_UP;
                            rd_addr    = AW'(count_reg - 1'b1);
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (idx_reg >= count_reg)
                        begin
                            pend_kind_next = K_ACK;
                            state_next     = S_EMIT;
                        end
                        else if (rd_data.id == id_reg)
                        begin
                            pos_next   = idx_reg;
                            rd_addr    = AW'(idx_reg + 1'b1);
                            state_next = S_SHIFT_DN;
                        end
                        else
                        begin
                            idx_next   = idx_reg + 1'b1;
                            rd_addr    = AW'(idx_reg + 1'b1);
                            state_next = S_HEAD_RD;
                        end
                    end
                    OP_DISP:
                    begin
                        if (count_reg != '0 && rd_data.etime <= present_reg
                            && fired_reg < FW'(MAX_FIRED))
                        begin
                            if (out_free)
                            begin
                                ovalid_next = 1'b1;
                                kind_next   = K_FIRED;
                                fid_next    = rd_data.id;
                                val_next    = '0;
                                last_next   = 1'b0;
                                fired_next  = fired_reg + 1'b1;
                                pos_next    = '0;
                                idx_next    = '0;
                                rd_addr     = AW'(1);
                                state_next  = S_SHIFT_DN;
                            end
                        end
                        else
                        begin
                            state_next = S_SCHED;
                        end
                    end
                    default:
                    begin
                        if (count_reg == '0)
                        begin
                            pend_kind_next = K_NONE;
                            state_next     = S_EMIT;
                        end
                        else if (out_free)
                        begin
                            ovalid_next = 1'b1;
                            kind_next   = K_NEXT;
                            fid_next    = rd_data.id;
                            val_next    = rd_data.etime;
                            last_next   = 1'b1;
                            state_next  = S_IDLE;
                        end
                    end
                endcase
            end
            S_HEAD_RD:
            begin
                // wait for the read issued at idx_reg to reach rd_data
                state_next = S_SCAN;
            end
            S_SHIFT_UP:
            begin
                // idx_reg is the destination; rd_data holds slot idx_reg-1
                if (idx_reg == pos_reg)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = pos_reg[AW-1:0];
                    count_next = count_reg + 1'b1;
                    if (pos_reg == '0)
                    begin
                        idx_next   = '0;
                        state_next = S_HEAD_CHK;
                    end
                    else
                    begin
                        pend_kind_next = K_ACK;
                        state_next     = S_EMIT;
                    end
                end
                else
                begin
                    // keep slot idx_reg-1 on the read port for the move
                    rd_addr         = AW'(idx_reg - 1'b1);
                    state_next      = S_HEAD_CHK;
                    pend_sched_next = 1'b1;
                end
            end
            S_HEAD_CHK:
            begin
                if (pend_sched_reg)
                begin
                    // rd_data now valid for slot idx_reg-1
                    wr_en           = 1'b1;
                    wr_addr         = idx_reg[AW-1:0];
                    wr_data         = rd_data;
                    idx_next        = idx_reg - 1'b1;
                    rd_addr         = AW'(idx_reg - 2'd2);
                    pend_sched_next = 1'b0;
                    state_next      = S_SHIFT_UP;
                end
                else
                begin
                    // read of slot 0 issued; schedule next cycle
                    rd_addr    = '0;
                    state_next = S_SCHED;
                end
            end
            S_SHIFT_DN:
            begin
                // rd_data holds slot pos_reg+1 read last cycle
                if (pos_reg + 1'b1 < count_reg)
                begin
                    wr_en    = 1'b1;
                    wr_addr  = pos_reg[AW-1:0];
                    wr_data  = rd_data;
                    pos_next = pos_reg + 1'b1;
                    rd_addr  = AW'(pos_reg + 2'd2);
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                    rd_addr    = '0;
                    idx_next   = '0;
                    if (op_reg == OP_DISP)
                    begin
                        state_next = S_HEAD_RD;
                    end
                    else if (idx_reg == '0)
                    begin
                        state_next = S_SCHED;
                    end
                    else
                    begin
                        pend_kind_next = K_ACK;
                        state_next     = S_EMIT;
                    end
                end
            end
            S_SCHED:
            begin
                // rd_data holds slot 0
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    fid_next    = '0;
                    last_next   = 1'b1;
                    state_next  = S_IDLE;
                    if (count_reg == '0)
                    begin
                        kind_next = K_COMPARE;
                        val_next  = {32'd0, lastcnt_reg + MAX_DELTA};
                    end
                    else if (rd_data.etime <= present_reg)
                    begin
                        kind_next = K_FIRE_NOW;
                        val_next  = '0;
                    end
                    else
                    begin
                        kind_next = K_COMPARE;
                        if (delta > {32'd0, MAX_DELTA})
                        begin
                            val_next = {32'd0, lastcnt_reg + MAX_DELTA};
                        end
                        else
                        begin
                            val_next = {32'd0, lastcnt_reg + delta[31:0]};
                        end
                    end
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    kind_next   = pend_kind_reg;
                    fid_next    = '0;
                    val_next    = (pend_kind_reg == K_TIME) ? present_reg : 64'd0;
                    last_next   = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid    = ovalid_reg;
    assign result_kind  = kind_reg;
    assign fired_id     = fid_reg;
    assign result_value = val_reg;
    assign last_result  = last_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("slot count beyond depth");

    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall)
        else $error("input taken while busy");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(result_kind)))
        else $error("stalled result changed");

endmodule

[tb/tb_timer_event_queue.sv]
module tb_timer_event_queue;
    import teq_pkg::*;

    localparam int DEPTH = 16;

    typedef struct {
        kind_t       kind;
        logic [31:0] id;
        logic [63:0] value;
        logic        last;
    } result_t;

    typedef struct {
        op_t         op;
        logic [31:0] counter;
        logic [63:0] etime;
        logic [31:0] eid;
        logic        has_kind;
        kind_t       want_kind;
    } vector_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  opcode;
    logic [31:0] counter_now;
    logic [63:0] event_time;
    logic [31:0] event_id;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  result_kind;
    logic [31:0] fired_id;
    logic [63:0] result_value;
    logic        last_result;

    // predictor state
    logic [63:0] q_time [DEPTH];
    logic [31:0] q_id [DEPTH];
    int          q_count;
    logic [63:0] now_time;
    logic [31:0] last_cnt;
    logic        running;

    result_t     pending_results [$];
    kind_t       typed_kinds [$];
    int          mismatches;
    int          send_idle_pct;
    int          recv_stall_pct;
    logic [31:0] counter_base;
    int          id_seq;

    timer_event_queue #(.QUEUE_DEPTH(DEPTH)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .opcode(opcode), .counter_now(counter_now),
        .event_time(event_time), .event_id(event_id),
        .out_valid(out_valid), .out_stall(out_stall),
        .result_kind(result_kind), .fired_id(fired_id),
        .result_value(result_value), .last_result(last_result)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    initial
    begin
        #20000000;
        $display("Mismatches found");
        $finish;
    end

    task automatic report(input string what);
        begin
            $display("MISMATCH at %0t: %s", $realtime, what);
            mismatches++;
        end
    endtask

    task automatic push_result(input kind_t k, input logic [31:0] id, input logic [63:0] v);
        result_t r;
        begin
            r.kind = k;
            r.id = id;
            r.value = v;
            r.last = 1'b0;
            pending_results.push_back(r);
        end
    endtask

    function automatic logic [31:0] compare_at(input logic [63:0] delta);
        begin
            if (delta > {32'd0, MAX_DELTA})
                return last_cnt + MAX_DELTA;
            return last_cnt + delta[31:0];
        end
    endfunction

    task automatic push_schedule();
        begin
            if (q_count == 0)
                push_result(K_COMPARE, 0, {32'd0, last_cnt + MAX_DELTA});
            else if (q_time[0] <= now_time)
                push_result(K_FIRE_NOW, 0, 0);
            else
                push_result(K_COMPARE, 0, {32'd0, compare_at(q_time[0] - now_time)});
        end
    endtask

    task automatic queue_insert(input logic [63:0] t, input logic [31:0] id);
        int pos;
        begin
            pos = 0;
            if (q_count >= DEPTH)
            begin
                push_result(K_FULL, 0, 0);
                return;
            end
            while (pos < q_count && t >= q_time[pos])
                pos++;
            for (int i = q_count; i > pos; i--)
            begin
                q_time[i] = q_time[i-1];
                q_id[i] = q_id[i-1];
            end
            q_time[pos] = t;
            q_id[pos] = id;
            q_count++;
            if (pos == 0)
                push_schedule();
            else
                push_result(K_ACK, 0, 0);
        end
    endtask

    task automatic queue_drop(input int pos);
        begin
            for (int i = pos; i < q_count - 1; i++)
            begin
                q_time[i] = q_time[i+1];
                q_id[i] = q_id[i+1];
            end
            q_count--;
        end
    endtask

    task automatic predict_events(input op_t op, input logic [31:0] cnt,
                                  input logic [63:0] et, input logic [31:0] eid);
        int pos;
        int fired;
        int first;
        logic [63:0] t;
        begin
            first = pending_results.size();
            if (!running)
            begin
                running = 1'b1;
                last_cnt = cnt;
            end
            else
            begin
                now_time = now_time + {32'd0, cnt - last_cnt};
                last_cnt = cnt;
            end
            case (op)
                OP_INS64: queue_insert(et, eid);
                OP_INS32:
                begin
                    t = {now_time[63:32], et[31:0]};
                    if (et[31:0] < now_time[31:0])
                        t = t + 64'h1_0000_0000;
                    queue_insert(t, eid);
                end
                OP_REMOVE:
                begin
                    pos = 0;
                    while (pos < q_count && q_id[pos] != eid)
                        pos++;
                    if (pos >= q_count)
                        push_result(K_ACK, 0, 0);
                    else
                    begin
                        queue_drop(pos);
                        if (pos == 0)
                            push_schedule();
                        else
                            push_result(K_ACK, 0, 0);
                    end
                end
                OP_DISP:
                begin
                    fired = 0;
                    while (q_count > 0 && q_time[0] <= now_time && fired < MAX_FIRED)
                    begin
                        push_result(K_FIRED, q_id[0], 0);
                        queue_drop(0);
                        fired++;
                    end
                    push_schedule();
                end
                OP_TIME: push_result(K_TIME, 0, now_time);
                OP_PEEK:
                    if (q_count > 0)
                        push_result(K_NEXT, q_id[0], q_time[0]);
                    else
                        push_result(K_NONE, 0, 0);
                default: push_result(K_NONE, 0, 0);
            endcase
            pending_results[pending_results.size()-1].last = 1'b1;
            if (pending_results.size() < first + 1)
                report("predictor produced no result");
        end
    endtask

    // receiver: stall at random, check on the rising edge
    always @(posedge clk)
    begin
        result_t r;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                report($sformatf("unexpected result kind %0d", result_kind));
            else
            begin
                r = pending_results.pop_front();
                if (result_kind !== r.kind)
                    report($sformatf("kind %0d, want %0d", result_kind, r.kind));
                if (fired_id !== r.id)
                    report($sformatf("id %h, want %h", fired_id, r.id));
                if (result_value !== r.value)
                    report($sformatf("value %h, want %h", result_value, r.value));
                if (last_result !== r.last)
                    report($sformatf("last %b, want %b", last_result, r.last));
                if (r.last && typed_kinds.size() > 0)
                begin
                    if (result_kind !== typed_kinds[0])
                        report($sformatf("table kind %0d, want %0d",
                                         result_kind, typed_kinds[0]));
                    void'(typed_kinds.pop_front());
                end
            end
        end
    end

    always @(negedge clk)
        out_stall <= rst_n ? ($urandom_range(99) < recv_stall_pct) : 1'b0;

    // leaves valid up after the accept; the next item or an idle cycle takes it down
    task automatic send_item(input op_t op, input logic [31:0] cnt,
                             input logic [63:0] et, input logic [31:0] eid);
        begin
            while ($urandom_range(99) < send_idle_pct)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
            in_valid <= 1'b1;
            opcode <= op;
            counter_now <= cnt;
            event_time <= et;
            event_id <= eid;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            predict_events(op, cnt, et, eid);
            @(negedge clk);
        end
    endtask

    // advance the counter by a small step most of the time, sometimes wrap far
    function automatic logic [31:0] next_counter();
        begin
            case ($urandom_range(9))
                0: counter_base = counter_base + $urandom();
                1: counter_base = counter_base + 32'h8000_0000 + $urandom_range(1000);
                default: counter_base = counter_base + $urandom_range(3000);
            endcase
            return counter_base;
        end
    endfunction

    task automatic random_item();
        op_t op;
        logic [63:0] et;
        logic [31:0] eid;
        int pick;
        begin
            pick = $urandom_range(99);
            eid = id_seq;
            if (pick < 22)
                op = OP_INS64;
            else if (pick < 42)
                op = OP_INS32;
            else if (pick < 60)
                op = OP_REMOVE;
            else if (pick < 80)
                op = OP_DISP;
            else if (pick < 88)
                op = OP_TIME;
            else if (pick < 96)
                op = OP_PEEK;
            else
                op = op_t'($urandom_range(7));
            case ($urandom_range(5))
                0: et = {$urandom(), $urandom()};
                1: et = now_time - $urandom_range(5000);
                2: et = now_time + {32'd0, $urandom()} + {$urandom_range(1), 32'd0};
                default: et = now_time + $urandom_range(8000);
            endcase
            if (op == OP_INS32)
                et = {$urandom(), et[31:0]};
            if (op == OP_REMOVE)
            begin
                if (q_count > 0 && $urandom_range(3) != 0)
                    eid = q_id[$urandom_range(q_count - 1)];
                else
                    eid = $urandom();
            end
            else if (op == OP_INS64 || op == OP_INS32)
            begin
                if ($urandom_range(7) == 0)
                    eid = $urandom();
                id_seq++;
            end
            send_item(op, next_counter(), et, eid);
        end
    endtask

    task automatic drain();
        begin
            in_valid <= 1'b0;
            while (pending_results.size() > 0)
                @(posedge clk);
            repeat (50) @(posedge clk);
            @(negedge clk);
        end
    endtask

    vector_t vectors [$];

    task automatic add_row(input op_t op, input logic [31:0] cnt, input logic [63:0] et,
                           input logic [31:0] eid, input logic hk, input kind_t k);
        vector_t v;
        begin
            v.op = op;
            v.counter = cnt;
            v.etime = et;
            v.eid = eid;
            v.has_kind = hk;
            v.want_kind = k;
            vectors.push_back(v);
        end
    endtask

    initial
    begin
        mismatches = 0;
        q_count = 0;
        now_time = 0;
        last_cnt = 0;
        running = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        counter_base = 0;
        id_seq = 100;
        rst_n = 1'b0;
        in_valid = 1'b0;
        opcode = OP_INS64;
        counter_now = 0;
        event_time = 0;
        event_id = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // first item captures the counter near the top, later ones wrap
        add_row(OP_TIME,   32'hFFFF_FF00, 64'd0, 0, 1, K_TIME);
        add_row(OP_PEEK,   32'hFFFF_FF00, 64'd0, 0, 1, K_NONE);
        add_row(OP_DISP,   32'hFFFF_FF10, 64'd0, 0, 1, K_COMPARE);
        add_row(OP_INS64,  32'h0000_0010, 64'd500, 1, 0, K_ACK);
        add_row(OP_INS64,  32'h0000_0020, 64'd500, 2, 1, K_ACK);
        add_row(OP_INS64,  32'h0000_0020, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1, K_ACK);
        add_row(OP_INS64,  32'h0000_0020, 64'd0, 0, 1, K_FIRE_NOW);
        add_row(OP_INS32,  32'h0000_0030, 64'hFFFF_FFFF_0000_0005, 3, 0, K_ACK);
        add_row(OP_INS32,  32'h0000_0030, 64'h0000_0000_FFFF_FFFF, 4, 0, K_ACK);
        add_row(OP_PEEK,   32'h0000_0030, 64'd0, 0, 1, K_NEXT);
        add_row(OP_REMOVE, 32'h0000_0040, 64'd0, 32'h1234_5678, 1, K_ACK);
        add_row(OP_REMOVE, 32'h0000_0040, 64'd0, 2, 1, K_ACK);
        add_row(OP_REMOVE, 32'h0000_0040, 64'd0, 0, 0, K_ACK);
        add_row(OP_DISP,   32'h0000_0400, 64'd0, 0, 0, K_ACK);
        add_row(OP_RSV6,   32'h0000_0500, 64'd0, 0, 1, K_NONE);
        add_row(OP_RSV7,   32'h0000_0500, 64'd0, 0, 1, K_NONE);
        for (int i = 0; i < 17; i++)
            add_row(OP_INS64, 32'h0000_0600, 64'h0000_0001_0000_0000 + i, 200 + i,
                    i == 16, K_FULL);
        add_row(OP_DISP,   32'hFFFF_FFFF, 64'd0, 0, 0, K_ACK);
        add_row(OP_DISP,   32'hFFFF_FFFF, 64'd0, 0, 0, K_ACK);
        add_row(OP_TIME,   32'hFFFF_FFFF, 64'd0, 0, 0, K_ACK);

        foreach (vectors[i])
        begin
            if (vectors[i].has_kind)
                typed_kinds.push_back(vectors[i].want_kind);
            send_item(vectors[i].op, vectors[i].counter, vectors[i].etime, vectors[i].eid);
            drain();
        end
        counter_base = 32'hFFFF_FFFF;

        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = (ph == 1 || ph == 3) ? 61 : 0;
            recv_stall_pct = (ph == 2) ? 61 : 0;
            if (ph == 3)
            begin
                send_idle_pct = 36;
                recv_stall_pct = 36;
            end
            for (int n = 0; n < 24; n++)
                random_item();
        end
        drain();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
